[rtl/ugb_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the uniform grid broad-phase block
// no dependencies

package ugb_pkg;

  localparam int DEF_MAX_COLUMNS   = 16;
  localparam int DEF_MAX_ROWS      = 16;
  localparam int DEF_CELL_CAPACITY = 16;
  localparam int DEF_MAX_FOUND     = 64;

  localparam int SIZE_W  = 13;  // cell size register width
  localparam int COUNT_W = 5;   // grid count register width
  localparam int CFG_W   = 13;  // config write data width
  localparam int MAG_W   = 16;  // magnitude of an edge, fits every legal sum
  localparam int EDGE_W  = 18;  // signed edge after momentum and size are added
  localparam int ID_W    = 10;

  localparam logic [SIZE_W-1:0]  RST_CELL_SIZE = 13'd64;
  localparam logic [COUNT_W-1:0] RST_COUNT     = 5'd16;

  typedef enum logic [1:0] {
    CFG_CELL_WIDTH   = 2'd0,
    CFG_CELL_HEIGHT  = 2'd1,
    CFG_GRID_COLUMNS = 2'd2,
    CFG_GRID_ROWS    = 2'd3
  } cfg_index_t;

  localparam logic [1:0] MODE_INSERT   = 2'd0;
  localparam logic [1:0] MODE_RETRIEVE = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_HIT      = 3'd2;
  localparam logic [2:0] ST_NONE     = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  typedef struct packed {
    logic [1:0]         mode;
    logic [ID_W-1:0]    object_id;
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic [11:0]        box_width;
    logic [11:0]        box_height;
    logic signed [11:0] move_x;
    logic signed [11:0] move_y;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] found_id;
    logic [2:0]      status;
    logic            last;
  } out_item_t;

  // divider handshake between sequencer and divider
  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/ugb_div.sv]
`timescale 1ns / 1ps
// restoring unsigned divider, one quotient bit per cycle
// depends on ugb_pkg

module ugb_div (
  input  logic              clk,
  input  logic              rst,
  input  ugb_pkg::div_req_t req,
  output ugb_pkg::div_rsp_t rsp
);

  localparam int QW = ugb_pkg::MAG_W;
  localparam int SW = ugb_pkg::SIZE_W;
  localparam int CW = $clog2(QW);

  logic [SW-1:0] rem;
  logic [SW-1:0] dvs;
  logic [QW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [SW:0]   trial;
  logic          ge;

  assign trial = {rem, quo[QW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvs  <= req.divisor;
        quo  <= req.dividend;
      end else if (busy) begin
        rem <= ge ? SW'(trial - {1'b0, dvs}) : trial[SW-1:0];
        quo <= {quo[QW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[rtl/ugb_store.sv]
`timescale 1ns / 1ps
// fill counts and member ids, two synchronous memories with registered reads
// depends on ugb_pkg

module ugb_store #(
  parameter int NUM_CELLS     = ugb_pkg::DEF_MAX_COLUMNS * ugb_pkg::DEF_MAX_ROWS,
  parameter int CELL_CAPACITY = ugb_pkg::DEF_CELL_CAPACITY
) (
  input  logic                                       clk,
  input  logic                                       fill_re,
  input  logic [$clog2(NUM_CELLS)-1:0]               fill_raddr,
  output logic [$clog2(CELL_CAPACITY+1)-1:0]         fill_rdata,
  input  logic                                       fill_we,
  input  logic [$clog2(NUM_CELLS)-1:0]               fill_waddr,
  input  logic [$clog2(CELL_CAPACITY+1)-1:0]         fill_wdata,
  input  logic                                       memb_re,
  input  logic [$clog2(NUM_CELLS*CELL_CAPACITY)-1:0] memb_raddr,
  output logic [ugb_pkg::ID_W-1:0]                   memb_rdata,
  input  logic                                       memb_we,
  input  logic [$clog2(NUM_CELLS*CELL_CAPACITY)-1:0] memb_waddr,
  input  logic [ugb_pkg::ID_W-1:0]                   memb_wdata
);

  localparam int FW = $clog2(CELL_CAPACITY + 1);

  logic [FW-1:0]            fill_mem [NUM_CELLS];
  logic [ugb_pkg::ID_W-1:0] memb_mem [NUM_CELLS * CELL_CAPACITY];

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (fill_re) begin
      fill_rdata <= fill_mem[fill_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (memb_we) begin
      memb_mem[memb_waddr] <= memb_wdata;
    end
    if (memb_re) begin
      memb_rdata <= memb_mem[memb_raddr];
    end
  end

endmodule

[rtl/uniform_grid_broadphase_core.sv]
`timescale 1ns / 1ps
// uniform grid broad-phase: one item at a time; after the accept cycle four divisions
// set the cell span; then insert reads each covered cell and adds the id where there is
// room, and retrieve reads each covered cell and each of its ids (stalls when the output
// is not taken); clear sweeps every cell at one a cycle; a finish state loads the final
// result; a retrieve cut at the id limit ends on its truncated id. after reset the same
// sweep runs and no item is accepted until it ends; config writes are taken at all times

module uniform_grid_broadphase_core #(
  parameter int MAX_COLUMNS   = ugb_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS      = ugb_pkg::DEF_MAX_ROWS,
  parameter int CELL_CAPACITY = ugb_pkg::DEF_CELL_CAPACITY,
  parameter int MAX_FOUND     = ugb_pkg::DEF_MAX_FOUND
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ugb_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ugb_pkg::out_item_t        out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [ugb_pkg::CFG_W-1:0] cfg_data
);

  localparam int NUM_CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int NUM_MEMB  = NUM_CELLS * CELL_CAPACITY;
  localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW  = $clog2(NUM_CELLS);
  localparam int MW  = $clog2(NUM_MEMB);
  localparam int FW  = $clog2(CELL_CAPACITY + 1);
  localparam int NW  = $clog2(MAX_FOUND + 1);
  localparam int QW  = ugb_pkg::MAG_W;
  localparam int SW  = ugb_pkg::SIZE_W;
  localparam int EW  = ugb_pkg::EDGE_W;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DIV_GO   = 9'b000000010,
    S_DIV_WAIT = 9'b000000100,
    S_CELL_RD  = 9'b000001000,
    S_CELL_CHK = 9'b000010000,
    S_MEMB_RD  = 9'b000100000,
    S_MEMB_USE = 9'b001000000,
    S_FINISH   = 9'b010000000,
    S_SWEEP    = 9'b100000000
  } state_t;

  state_t state;

  // configuration registers
  logic [SW-1:0]               cell_width;
  logic [SW-1:0]               cell_height;
  logic [ugb_pkg::COUNT_W-1:0] grid_columns;
  logic [ugb_pkg::COUNT_W-1:0] grid_rows;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width   <= ugb_pkg::RST_CELL_SIZE;
      cell_height  <= ugb_pkg::RST_CELL_SIZE;
      grid_columns <= ugb_pkg::RST_COUNT;
      grid_rows    <= ugb_pkg::RST_COUNT;
    end else if (cfg_valid) begin
      unique case (ugb_pkg::cfg_index_t'(cfg_index))
        ugb_pkg::CFG_CELL_WIDTH:   cell_width   <= cfg_data[SW-1:0];
        ugb_pkg::CFG_CELL_HEIGHT:  cell_height  <= cfg_data[SW-1:0];
        ugb_pkg::CFG_GRID_COLUMNS: grid_columns <= cfg_data[ugb_pkg::COUNT_W-1:0];
        ugb_pkg::CFG_GRID_ROWS:    grid_rows    <= cfg_data[ugb_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective grid bounds: highest usable column and row index
  logic [CW-1:0] col_max;
  logic [RW-1:0] row_max;

  always_comb begin
    if (grid_columns == '0) begin
      col_max = '0;
    end else if (32'(grid_columns) > 32'(MAX_COLUMNS)) begin
      col_max = CW'(MAX_COLUMNS - 1);
    end else begin
      col_max = CW'(grid_columns - 1'b1);
    end
    if (grid_rows == '0) begin
      row_max = '0;
    end else if (32'(grid_rows) > 32'(MAX_ROWS)) begin
      row_max = RW'(MAX_ROWS - 1);
    end else begin
      row_max = RW'(grid_rows - 1'b1);
    end
  end

  // item registers
  logic [1:0]               mode;
  logic [ugb_pkg::ID_W-1:0] obj_id;
  logic [QW-1:0]            mag [4];   // x high, x low, y high, y low edge magnitudes
  logic [3:0]               neg;
  logic [1:0]               div_sel;
  logic                     sweep_reply;

  // edges at accept time, sign and magnitude for the divider
  logic signed [EW-1:0] lx, rx, ty, by;
  logic signed [EW-1:0] mvx, mvy;
  logic                 is_retrieve;

  assign is_retrieve = in_item.mode == ugb_pkg::MODE_RETRIEVE;
  assign mvx = is_retrieve ? EW'(in_item.move_x) : '0;
  assign mvy = is_retrieve ? EW'(in_item.move_y) : '0;
  assign lx  = EW'(in_item.box_left) + mvx;
  assign ty  = EW'(in_item.box_top) + mvy;
  assign rx  = lx + EW'({1'b0, in_item.box_width});
  assign by  = ty + EW'({1'b0, in_item.box_height});

  function automatic logic [QW-1:0] mag_of(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] a;
    a = v[EW-1] ? -v : v;
    return a[QW-1:0];
  endfunction

  // divider
  ugb_pkg::div_req_t div_req;
  ugb_pkg::div_rsp_t div_rsp;
  logic [SW-1:0]     dvs_raw;

  assign dvs_raw          = div_sel[1] ? cell_height : cell_width;
  assign div_req.start    = state == S_DIV_GO;
  assign div_req.dividend = mag[div_sel];
  assign div_req.divisor  = (dvs_raw == '0) ? SW'(1) : dvs_raw;

  ugb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // cell span
  logic [CW-1:0] x_lo, x_hi, col;
  logic [RW-1:0] y_lo, y_hi, row;
  logic          x_empty, y_empty;

  // storage
  logic          fill_re, fill_we, memb_re, memb_we;
  logic [AW-1:0] cell_addr, fill_waddr;
  logic [FW-1:0] fill_rdata, fill_wdata;
  logic [MW-1:0] memb_addr;
  logic [ugb_pkg::ID_W-1:0] memb_rdata;
  logic [AW-1:0] sweep_addr;
  logic [FW-1:0] fill_cnt, k;

  assign cell_addr = AW'(AW'(col) * AW'(MAX_ROWS) + AW'(row));
  assign memb_addr = MW'(MW'(cell_addr) * MW'(CELL_CAPACITY) +
                         MW'(state == S_CELL_CHK ? fill_rdata : k));

  ugb_store #(
    .NUM_CELLS     (NUM_CELLS),
    .CELL_CAPACITY (CELL_CAPACITY)
  ) u_store (
    .clk        (clk),
    .fill_re    (fill_re),
    .fill_raddr (cell_addr),
    .fill_rdata (fill_rdata),
    .fill_we    (fill_we),
    .fill_waddr (fill_waddr),
    .fill_wdata (fill_wdata),
    .memb_re    (memb_re),
    .memb_raddr (memb_addr),
    .memb_rdata (memb_rdata),
    .memb_we    (memb_we),
    .memb_waddr (memb_addr),
    .memb_wdata (obj_id)
  );

  // result bookkeeping; one found id is held back so that the final one can be
  // marked last, or truncated when one more id turns up past the limit
  logic                     full;
  logic                     pend_valid;
  logic [ugb_pkg::ID_W-1:0] pend_id;
  logic [NW-1:0]            found_cnt;
  logic                     cell_full;
  logic                     last_cell;

  // output register
  logic               can_push, push;
  ugb_pkg::out_item_t push_item;

  assign can_push  = !out_valid || out_ready;
  assign cell_full = fill_rdata >= FW'(CELL_CAPACITY);
  assign last_cell = (row == y_hi) && (col == x_hi);

  assign in_ready = state == S_IDLE;

  // memory port control; the walk never touches one cell twice in a row and
  // each read-modify-write finishes before the next read, so no forwarding
  always_comb begin
    fill_re    = state == S_CELL_RD;
    memb_re    = state == S_MEMB_RD;
    fill_we    = 1'b0;
    fill_waddr = cell_addr;
    fill_wdata = FW'(fill_rdata + 1'b1);
    memb_we    = 1'b0;
    if (state == S_SWEEP) begin
      fill_we    = 1'b1;
      fill_waddr = sweep_addr;
      fill_wdata = '0;
    end else if (state == S_CELL_CHK && mode == ugb_pkg::MODE_INSERT && !cell_full) begin
      fill_we = 1'b1;
      memb_we = 1'b1;
    end
  end

  // what goes into the output register this cycle
  always_comb begin
    push      = 1'b0;
    push_item = '0;
    unique case (state)
      S_MEMB_USE: begin
        if (pend_valid) begin
          push               = can_push;
          push_item.found_id = pend_id;
          push_item.status   = ugb_pkg::ST_HIT;
          if (found_cnt == NW'(MAX_FOUND)) begin
            push_item.status = ugb_pkg::ST_TRUNC;
            push_item.last   = 1'b1;
          end
        end
      end
      S_FINISH: begin
        push           = can_push;
        push_item.last = 1'b1;
        priority case (mode)
          ugb_pkg::MODE_INSERT:
            push_item.status = full ? ugb_pkg::ST_FULL : ugb_pkg::ST_INSERTED;
          ugb_pkg::MODE_RETRIEVE: begin
            push_item.status   = pend_valid ? ugb_pkg::ST_HIT : ugb_pkg::ST_NONE;
            push_item.found_id = pend_valid ? pend_id : '0;
          end
          default: push_item.status = ugb_pkg::ST_CLEARED;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_item <= push_item;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_addr  <= '0;
      sweep_reply <= 1'b0;
      pend_valid  <= 1'b0;
      found_cnt   <= '0;
      full        <= 1'b0;
      div_sel     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode       <= in_item.mode;
            obj_id     <= in_item.object_id;
            mag[0]     <= mag_of(rx);
            mag[1]     <= mag_of(lx);
            mag[2]     <= mag_of(by);
            mag[3]     <= mag_of(ty);
            neg        <= {ty[EW-1], by[EW-1], lx[EW-1], rx[EW-1]};
            div_sel    <= '0;
            pend_valid <= 1'b0;
            found_cnt  <= '0;
            full       <= 1'b0;
            sweep_addr <= '0;
            priority if (in_item.mode == ugb_pkg::MODE_CLEAR) begin
              sweep_reply <= 1'b1;
              state       <= S_SWEEP;
            end else if (in_item.mode == ugb_pkg::MODE_INSERT || is_retrieve) begin
              state <= S_DIV_GO;
            end else begin
              // unused mode: taken and dropped without a result
              state <= S_IDLE;
            end
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            unique case (div_sel)
              2'd0: begin
                x_empty <= neg[0] && div_rsp.quotient != '0;
                if (neg[0]) x_hi <= '0;
                else if (div_rsp.quotient > QW'(col_max)) x_hi <= col_max;
                else x_hi <= CW'(div_rsp.quotient);
              end
              2'd1: begin
                x_lo <= '0;
                if (!neg[1]) begin
                  if (div_rsp.quotient > QW'(x_hi)) x_empty <= 1'b1;
                  else x_lo <= CW'(div_rsp.quotient);
                end
              end
              2'd2: begin
                y_empty <= neg[2] && div_rsp.quotient != '0;
                if (neg[2]) y_hi <= '0;
                else if (div_rsp.quotient > QW'(row_max)) y_hi <= row_max;
                else y_hi <= RW'(div_rsp.quotient);
              end
              default: begin
                y_lo <= '0;
                if (!neg[3]) begin
                  if (div_rsp.quotient > QW'(y_hi)) y_empty <= 1'b1;
                  else y_lo <= RW'(div_rsp.quotient);
                end
              end
            endcase
            div_sel <= div_sel + 1'b1;
            state   <= (div_sel == 2'd3) ? S_CELL_RD : S_DIV_GO;
            col     <= x_lo;
            row     <= (div_sel == 2'd3 && !neg[3] && div_rsp.quotient <= QW'(y_hi)) ?
                       RW'(div_rsp.quotient) : '0;
          end
        end
        S_CELL_RD: begin
          // empty span on either axis covers no cell
          if (x_empty || y_empty) state <= S_FINISH;
          else state <= S_CELL_CHK;
        end
        S_CELL_CHK: begin
          fill_cnt <= fill_rdata;
          k        <= '0;
          if (mode == ugb_pkg::MODE_INSERT && cell_full) full <= 1'b1;
          if (mode == ugb_pkg::MODE_RETRIEVE && fill_rdata != '0) begin
            state <= S_MEMB_RD;
          end else if (last_cell) begin
            state <= S_FINISH;
          end else begin
            state <= S_CELL_RD;
            if (row == y_hi) begin
              row <= y_lo;
              col <= col + 1'b1;
            end else begin
              row <= row + 1'b1;
            end
          end
        end
        S_MEMB_RD: state <= S_MEMB_USE;
        S_MEMB_USE: begin
          if (found_cnt == NW'(MAX_FOUND)) begin
            if (can_push) begin
              pend_valid <= 1'b0;
              state      <= S_IDLE;
            end
          end else if (!pend_valid || can_push) begin
            pend_valid <= 1'b1;
            pend_id    <= memb_rdata;
            found_cnt  <= found_cnt + 1'b1;
            k          <= k + 1'b1;
            if (FW'(k + 1'b1) != fill_cnt) begin
              state <= S_MEMB_RD;
            end else if (last_cell) begin
              state <= S_FINISH;
            end else begin
              state <= S_CELL_RD;
              if (row == y_hi) begin
                row <= y_lo;
                col <= col + 1'b1;
              end else begin
                row <= row + 1'b1;
              end
            end
          end
        end
        S_FINISH: begin
          if (can_push) begin
            pend_valid  <= 1'b0;
            sweep_reply <= 1'b0;
            state       <= S_IDLE;
          end
        end
        S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == AW'(NUM_CELLS - 1)) begin
            state <= sweep_reply ? S_FINISH : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result is never loaded over one that still waits
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting result");

  // the found count never passes the limit
  a_found_bound: assert property (@(posedge clk) disable iff (rst)
    found_cnt <= NW'(MAX_FOUND))
    else $error("found count past limit");

  // a cell never counts more ids than it can hold
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill_we && state != S_SWEEP) |-> fill_wdata <= FW'(CELL_CAPACITY))
    else $error("cell fill past capacity");

  // member data is consumed only after its read was issued
  a_memb_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_MEMB_USE) |-> ($past(state) == S_MEMB_RD || $past(state) == S_MEMB_USE))
    else $error("member data used without read");

endmodule
